// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/msp_cr_pkg.sv =====
`default_nettype none

package msp_cr_pkg;

   // largest accepted request payload
   localparam int unsigned MAX_PAYLOAD = 255;

   // response framing bytes
   localparam logic [7:0] HDR_DOLLAR = 8'h24;
   localparam logic [7:0] HDR_M      = 8'h4D;
   localparam logic [7:0] HDR_GT     = 8'h3E;

   // command codes
   localparam logic [7:0] CMD_API_VERSION     = 8'd1;
   localparam logic [7:0] CMD_FC_VARIANT      = 8'd2;
   localparam logic [7:0] CMD_FC_VERSION      = 8'd3;
   localparam logic [7:0] CMD_BOARD_INFO      = 8'd4;
   localparam logic [7:0] CMD_BUILD_INFO      = 8'd5;
   localparam logic [7:0] CMD_FEATURE_CONFIG  = 8'd36;
   localparam logic [7:0] CMD_IDENT           = 8'd100;
   localparam logic [7:0] CMD_STATUS          = 8'd101;
   localparam logic [7:0] CMD_MOTOR           = 8'd104;
   localparam logic [7:0] CMD_BATTERY_STATE   = 8'd130;
   localparam logic [7:0] CMD_UID             = 8'd160;
   localparam logic [7:0] CMD_SET_PASSTHROUGH = 8'd245;
   localparam logic [7:0] CMD_DEBUG           = 8'd254;

   // request operation kinds
   localparam logic OP_RX_BYTE    = 1'b0;
   localparam logic OP_LOAD_MOTOR = 1'b1;

   localparam int unsigned BUILD_INFO_LEN = 19;
   localparam logic [7:0] BUILD_INFO [BUILD_INFO_LEN] = '{
      8'h4D, 8'h61, 8'h72, 8'h20, 8'h31, 8'h30, 8'h20, 8'h32, 8'h30, 8'h32,
      8'h36, 8'h31, 8'h32, 8'h3A, 8'h30, 8'h30, 8'h3A, 8'h30, 8'h30};

   typedef logic [4:0] resp_len_type;   // response payload length, up to 19
   typedef logic [4:0] resp_pos_type;   // byte position in a response, up to 24

   typedef struct packed {
      logic accept_en;   // request side open
      logic emit_en;     // response being sent
   } ctrl_cmd_type;

   typedef struct packed {
      logic answer;      // last request byte taken, frame is answered
      logic emit_done;   // final response byte taken
   } dp_status_type;

   function automatic logic cmd_known(input logic [7:0] cmd);
      logic known;
      case (cmd)
         CMD_API_VERSION, CMD_FC_VARIANT, CMD_FC_VERSION, CMD_BOARD_INFO,
         CMD_BUILD_INFO, CMD_FEATURE_CONFIG, CMD_IDENT, CMD_STATUS, CMD_MOTOR,
         CMD_BATTERY_STATE, CMD_UID, CMD_SET_PASSTHROUGH, CMD_DEBUG: known = 1'b1;
         default: known = 1'b0;
      endcase
      return known;
   endfunction

   function automatic resp_len_type resp_len(input logic [7:0] cmd);
      resp_len_type len;
      case (cmd)
         CMD_API_VERSION:     len = 5'd3;
         CMD_FC_VARIANT:      len = 5'd4;
         CMD_FC_VERSION:      len = 5'd3;
         CMD_BOARD_INFO:      len = 5'd6;
         CMD_BUILD_INFO:      len = 5'd19;
         CMD_FEATURE_CONFIG:  len = 5'd4;
         CMD_IDENT:           len = 5'd7;
         CMD_STATUS:          len = 5'd10;
         CMD_MOTOR:           len = 5'd8;
         CMD_BATTERY_STATE:   len = 5'd9;
         CMD_UID:             len = 5'd12;
         CMD_SET_PASSTHROUGH: len = 5'd1;
         CMD_DEBUG:           len = 5'd4;
         default:             len = 5'd0;
      endcase
      return len;
   endfunction

   // payload byte idx of the response to cmd; motors packed one in the low bits
   function automatic logic [7:0] payload_byte(input logic [7:0] cmd,
                                               input logic [4:0] idx,
                                               input logic [63:0] motors);
      logic [7:0] b;
      b = 8'h00;
      case (cmd)
         CMD_API_VERSION: begin
            case (idx)
               5'd1:    b = 8'd1;
               5'd2:    b = 8'd46;
               default: b = 8'h00;
            endcase
         end
         CMD_FC_VARIANT: begin
            case (idx)
               5'd0:    b = 8'h42;
               5'd1:    b = 8'h54;
               5'd2:    b = 8'h46;
               5'd3:    b = 8'h4C;
               default: b = 8'h00;
            endcase
         end
         CMD_FC_VERSION: begin
            case (idx)
               5'd0:    b = 8'd4;
               5'd1:    b = 8'd5;
               default: b = 8'h00;
            endcase
         end
         CMD_BOARD_INFO: begin
            case (idx)
               5'd0:    b = 8'h56;
               5'd1:    b = 8'h45;
               5'd2:    b = 8'h58;
               5'd3:    b = 8'h5F;
               default: b = 8'h00;
            endcase
         end
         CMD_BUILD_INFO: begin
            if (idx < 5'(BUILD_INFO_LEN)) begin
               b = BUILD_INFO[idx];
            end
         end
         CMD_MOTOR: begin
            if (idx < 5'd8) begin
               b = motors[{idx[2:0], 3'b000} +: 8];
            end
         end
         CMD_UID: begin
            case (idx)
               5'd0:    b = 8'h56;
               5'd1:    b = 8'h45;
               5'd2:    b = 8'h58;
               5'd3:    b = 8'h31;
               default: b = 8'h00;
            endcase
         end
         CMD_SET_PASSTHROUGH: begin
            if (idx == 5'd0) begin
               b = 8'd4;
            end
         end
         CMD_DEBUG: begin
            case (idx)
               5'd0:    b = 8'hDE;
               5'd1:    b = 8'hAD;
               5'd2:    b = 8'hBE;
               5'd3:    b = 8'hEF;
               default: b = 8'h00;
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/msp_cr_ctrl.sv =====
`default_nettype none

module msp_cr_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire msp_cr_pkg::dp_status_type status,
   output msp_cr_pkg::ctrl_cmd_type       cmd
);
   import msp_cr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.accept_en = 1'b0;
      cmd.emit_en   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept_en = 1'b1;
            if (status.answer) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit_en = 1'b1;
            if (status.emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/msp_cr_datapath.sv =====
`default_nettype none

module msp_cr_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire msp_cr_pkg::ctrl_cmd_type  cmd,
   output msp_cr_pkg::dp_status_type      status,
   input  wire logic                      req_tvalid,
   input  wire logic [71:0]               req_tdata,
   input  wire logic                      req_tlast,
   input  wire logic                      req_tuser,
   input  wire logic                      rsp_tready,
   output logic [7:0]                     rsp_tdata,
   output logic                           rsp_tlast,
   output logic                           rsp_tuser
);
   import msp_cr_pkg::*;

   localparam logic [8:0] COUNT_MAX = 9'h1FF;

   // parse state
   logic [8:0]  byte_count_ff, byte_count_in;
   logic [7:0]  decl_len_ff, decl_len_in;
   logic [7:0]  cmd_code_ff, cmd_code_in;
   logic [7:0]  rx_xor_ff, rx_xor_in;
   logic [7:0]  rx_chk_ff, rx_chk_in;
   logic [63:0] motor_ff;

   // response state
   logic [7:0]   resp_cmd_ff;
   resp_len_type resp_len_ff;
   logic         resp_pass_ff;
   resp_pos_type resp_pos_ff;
   logic [7:0]   resp_xor_ff;

   logic       accept_byte;
   logic       accept_motor;
   logic [7:0] rx_byte;
   logic [8:0] pay_end;
   logic [8:0] need;
   logic       frame_ok;
   logic       rsp_take;
   resp_pos_type last_pos;
   resp_pos_type pay_idx;
   logic [7:0]   tx_byte;

   assign rx_byte      = req_tdata[7:0];
   assign accept_byte  = req_tvalid && cmd.accept_en && (req_tuser == OP_RX_BYTE);
   assign accept_motor = req_tvalid && cmd.accept_en && (req_tuser == OP_LOAD_MOTOR);
   assign pay_end      = 9'd5 + {1'b0, decl_len_ff};

   always_comb begin
      decl_len_in   = decl_len_ff;
      cmd_code_in   = cmd_code_ff;
      rx_xor_in     = rx_xor_ff;
      rx_chk_in     = rx_chk_ff;
      if (byte_count_ff == 9'd3) begin
         decl_len_in = rx_byte;
         rx_xor_in   = rx_xor_ff ^ rx_byte;
      end else if (byte_count_ff == 9'd4) begin
         cmd_code_in = rx_byte;
         rx_xor_in   = rx_xor_ff ^ rx_byte;
      end else if (byte_count_ff >= 9'd5 && byte_count_ff < pay_end) begin
         rx_xor_in = rx_xor_ff ^ rx_byte;
      end else if (byte_count_ff >= 9'd5 && byte_count_ff == pay_end) begin
         rx_chk_in = rx_byte;
      end
      byte_count_in = (byte_count_ff < COUNT_MAX) ? byte_count_ff + 9'd1 : byte_count_ff;
   end

   assign need     = 9'd6 + {1'b0, decl_len_in};
   assign frame_ok = (byte_count_in >= 9'd6) && (byte_count_in >= need) &&
                     ({1'b0, decl_len_in} <= 9'(MAX_PAYLOAD)) &&
                     (rx_xor_in == rx_chk_in) && cmd_known(cmd_code_in);

   assign status.answer = accept_byte && req_tlast && frame_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         decl_len_ff   <= '0;
         cmd_code_ff   <= '0;
         rx_xor_ff     <= '0;
         rx_chk_ff     <= '0;
      end else if (accept_byte) begin
         if (req_tlast) begin
            // every request end returns the parser to its reset state
            byte_count_ff <= '0;
            decl_len_ff   <= '0;
            cmd_code_ff   <= '0;
            rx_xor_ff     <= '0;
            rx_chk_ff     <= '0;
         end else begin
            byte_count_ff <= byte_count_in;
            decl_len_ff   <= decl_len_in;
            cmd_code_ff   <= cmd_code_in;
            rx_xor_ff     <= rx_xor_in;
            rx_chk_ff     <= rx_chk_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_ff <= '0;
      end else if (accept_motor) begin
         motor_ff <= req_tdata[71:8];
      end
   end

   // response sequencing
   assign last_pos  = 5'd5 + resp_len_ff;
   assign pay_idx   = resp_pos_ff - 5'd5;
   assign rsp_take  = cmd.emit_en && rsp_tready;
   assign status.emit_done = rsp_take && (resp_pos_ff == last_pos);

   always_comb begin
      case (resp_pos_ff)
         5'd0:    tx_byte = HDR_DOLLAR;
         5'd1:    tx_byte = HDR_M;
         5'd2:    tx_byte = HDR_GT;
         5'd3:    tx_byte = {3'b000, resp_len_ff};
         5'd4:    tx_byte = resp_cmd_ff;
         default: begin
            if (resp_pos_ff == last_pos) begin
               tx_byte = resp_xor_ff;
            end else begin
               tx_byte = payload_byte(resp_cmd_ff, pay_idx, motor_ff);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (status.answer) begin
         resp_cmd_ff  <= cmd_code_in;
         resp_len_ff  <= resp_len(cmd_code_in);
         resp_pass_ff <= (cmd_code_in == CMD_SET_PASSTHROUGH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resp_pos_ff <= '0;
         resp_xor_ff <= '0;
      end else if (status.answer) begin
         resp_pos_ff <= '0;
         resp_xor_ff <= '0;
      end else if (rsp_take) begin
         resp_pos_ff <= resp_pos_ff + 5'd1;
         if (resp_pos_ff >= 5'd3) begin
            resp_xor_ff <= resp_xor_ff ^ tx_byte;
         end
      end
   end

   assign rsp_tdata = tx_byte;
   assign rsp_tlast = (resp_pos_ff == last_pos);
   assign rsp_tuser = resp_pass_ff;

endmodule

`default_nettype wire

// ===== rtl/msp_v1_command_responder.sv =====
`default_nettype none
`include "assert_macros.svh"

// msp v1 command responder. request words arrive on the req_ stream: with
// req_tuser low each word carries one received frame byte in req_tdata[7:0]
// and req_tlast marks the final byte of the received buffer; with req_tuser
// high the word loads the four stored motor values from req_tdata[71:8] and
// gives no response. bytes 0..2 of a frame are not checked, byte 3 is the
// payload length, byte 4 the command, then payload and checksum. on the last
// byte the frame is answered if it is long enough, the length is within
// MAX_PAYLOAD, the xor checksum matches and the command is known; otherwise
// it is dropped silently. the answer goes out on the rsp_ stream one byte a
// word as '$','M','>', length, command, payload, checksum, with rsp_tlast on
// the checksum byte and rsp_tuser high on every byte of a set-passthrough
// answer. request words are taken back to back while req_tready is high; an answered frame then holds
// req_tready low while its 6 + length response words (7 to 25) are sent,
// one per cycle that rsp_tready is high, as the sequencer walks the frame.
module msp_v1_command_responder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // rx_byte, motor_one, motor_two,
                                         // motor_three, motor_four
   input  wire logic        req_tlast,   // rx_last
   input  wire logic        req_tuser,   // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // tx_byte
   output logic             rsp_tlast,   // tx_last
   output logic             rsp_tuser    // passthrough_request
);
   import msp_cr_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // sequencer: idle while parsing, emit while a response is going out
   msp_cr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (dp_status),
      .cmd    (ctrl_cmd)
   );

   // parser, motor store and response byte generator
   msp_cr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctrl_cmd),
      .status     (dp_status),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = ctrl_cmd.accept_en;
   assign rsp_tvalid = ctrl_cmd.emit_en;

   // request side stays closed while a response is being sent
   `ASSERT_SAME(a_no_accept_in_emit, clock, reset, rsp_tvalid, !req_tready)
   // an answered frame starts its response with the header byte
   `ASSERT_NEXT(a_answer_starts_frame, clock, reset, dp_status.answer,
                rsp_tvalid && (rsp_tdata == HDR_DOLLAR))
   // after the checksum byte is taken the block is idle again
   `ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
                !rsp_tvalid && req_tready)

endmodule

`default_nettype wire
